@@ src/tsr_pkg.sv @@
// Shared types and constants of the trapezoid span rasterizer.
package tsr_pkg;

	localparam int MaxRows       = 64;
	localparam int BytesPerPixel = 2;
	localparam int RowCntW       = $clog2(MaxRows + 1);

	localparam logic [2:0] RegClipLeft   = 3'd0;
	localparam logic [2:0] RegClipTop    = 3'd1;
	localparam logic [2:0] RegClipRight  = 3'd2;
	localparam logic [2:0] RegClipBottom = 3'd3;
	localparam logic [2:0] RegFillColor  = 3'd4;
	localparam logic [2:0] RegRowStride  = 3'd5;
	localparam logic [2:0] RegFrameBase  = 3'd6;

	typedef struct packed {
		logic signed [15:0] top_row;
		logic signed [31:0] top_left_x;
		logic signed [31:0] top_right_x;
		logic signed [15:0] bottom_row;
		logic signed [31:0] bottom_left_x;
		logic signed [31:0] bottom_right_x;
	} trap_t;

	typedef struct packed {
		logic signed [15:0] span_row;
		logic signed [15:0] span_start;
		logic signed [15:0] span_end;
		logic        [16:0] span_length;
		logic        [31:0] start_address;
		logic        [15:0] span_color;
		logic               drawn;
		logic               last_span;
		logic               truncated;
	} span_t;

	// Divider handshake between sequencer and divider.
	typedef struct packed {
		logic               start;
		logic signed [33:0] dividend;
		logic        [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [33:0] quotient;
	} div_rsp_t;

endpackage

@@ src/tsr_if.sv @@
// Valid/ready channel carrying one payload type.
interface tsr_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/tsr_div.sv @@
// Radix-2 restoring divider, signed dividend by positive divisor, truncating.
module tsr_div (
	input  logic             clk,
	input  logic             arst_n,
	input  tsr_pkg::div_req_t req,
	output tsr_pkg::div_rsp_t rsp
);
	import tsr_pkg::*;

	logic        [33:0] mag_q;
	logic        [16:0] rem_q;
	logic        [16:0] den_q;
	logic               neg_q;
	logic        [5:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic        [17:0] trial;
	logic        [33:0] quo;

	assign trial = {rem_q, mag_q[33]} - {1'b0, den_q};
	assign quo   = neg_q ? (~mag_q + 34'd1) : mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd34;
				neg_q  <= req.dividend[33];
				mag_q  <= req.dividend[33] ? (~req.dividend + 34'd1) : req.dividend;
				rem_q  <= '0;
				den_q  <= req.divisor;
			end else if (busy_q) begin
				// shift one quotient bit in per cycle
				if (!trial[17]) begin
					rem_q <= trial[16:0];
					mag_q <= {mag_q[32:0], 1'b1};
				end else begin
					rem_q <= {rem_q[15:0], mag_q[33]};
					mag_q <= {mag_q[32:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{done: done_q, quotient: quo};

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("div done while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without work");
	a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == 6'd0 || $past(req.start)) else $error("count left over");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("start while busy");
endmodule

@@ src/trapezoid_span_rasterizer.sv @@
// Top level: trapezoid setup, vertical clip and per-row span emission.
//
//  channel   dir  payload
//  trap      in   tsr_pkg::trap_t  (one trapezoid)
//  span      out  tsr_pkg::span_t  (one span per clipped row, up to 64)
//  cfg_*     in   write enable, index, 32-bit data
//
// A trapezoid passes the accept and check states, then the two slope divisions through
// one shared 34-step divider, the setup steps (top-clip multiply, edge advance, row
// address), then the emit and output states per span, up to 64; a single-row item
// skips the divider; one with its bottom above its top ends after the check. The input
// is ready only in idle, from the cycle after the last span is taken; a stalled span
// holds in its output register. Reset zeroes all but item_q, prod_l_q, prod_r_q, out_q.
module trapezoid_span_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	tsr_if.sink         trap,
	tsr_if.source       span,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tsr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_DIVL, S_WAITL, S_DIVR, S_WAITR, S_CLIPM, S_CLIPA,
		S_ADDR, S_EMIT, S_OUT
	} state_t;

	state_t state_q;

	logic signed [15:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic        [15:0] fill_color_q, row_stride_q;
	logic        [31:0] frame_base_q;

	trap_t              item_q;
	logic signed [31:0] left_edge_q, right_edge_q, left_slope_q, right_slope_q;
	logic signed [15:0] current_row_q;
	logic        [16:0] rows_left_q;
	logic        [31:0] row_address_q;
	logic        [RowCntW-1:0] emit_q;
	logic               trunc_q;
	logic        [31:0] prod_l_q, prod_r_q;
	span_t              out_q;
	logic               out_valid_q;

	div_req_t           dreq;
	div_rsp_t           drsp;

	tsr_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic signed [17:0] nrows_in;
	logic signed [32:0] s1, s2, diff_l, diff_r;
	logic signed [16:0] dy;
	logic signed [17:0] y1c, y2c, nrows_c;
	logic signed [31:0] le, re, ls, rs;
	logic signed [15:0] ix1, ix2, st, en;
	logic               drw;

	assign nrows_in = 18'(item_q.bottom_row) - 18'(item_q.top_row) + 18'sd1;
	assign s1 = 33'(item_q.top_left_x) + 33'(item_q.bottom_left_x);
	assign s2 = 33'(item_q.top_right_x) + 33'(item_q.bottom_right_x);
	assign diff_l = 33'(item_q.bottom_left_x) - 33'(item_q.top_left_x);
	assign diff_r = 33'(item_q.bottom_right_x) - 33'(item_q.top_right_x);
	assign dy = 17'(clip_top_q) - 17'(item_q.top_row);

	// rows after clip
	assign y1c = (item_q.top_row < clip_top_q) ? 18'(clip_top_q) : 18'(item_q.top_row);
	assign y2c = (item_q.bottom_row > clip_bottom_q) ? 18'(clip_bottom_q)
		: 18'(item_q.bottom_row);
	assign nrows_c = y2c - y1c + 18'sd1;

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = 34'(diff_l);
		dreq.divisor  = 17'(nrows_in - 18'sd1);
		if (state_q == S_DIVL) dreq.start = 1'b1;
		if (state_q == S_DIVR) begin
			dreq.start    = 1'b1;
			dreq.dividend = 34'(diff_r);
		end
	end

	// swap crossed edges before forming the span
	always_comb begin
		if (left_edge_q > right_edge_q) begin
			le = right_edge_q; re = left_edge_q; ls = right_slope_q; rs = left_slope_q;
		end else begin
			le = left_edge_q; re = right_edge_q; ls = left_slope_q; rs = right_slope_q;
		end
		ix1 = le[31:16];
		ix2 = re[31:16];
		st  = (ix1 < clip_left_q) ? clip_left_q : ix1;
		en  = (ix2 > clip_right_q) ? clip_right_q : ix2;
		drw = (ix2 >= clip_left_q) && (ix1 <= clip_right_q) && (st <= en);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q <= '0; clip_top_q <= '0; clip_right_q <= '0;
			clip_bottom_q <= '0; fill_color_q <= '0; row_stride_q <= '0;
			frame_base_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegClipLeft:   clip_left_q   <= cfg_data[15:0];
				RegClipTop:    clip_top_q    <= cfg_data[15:0];
				RegClipRight:  clip_right_q  <= cfg_data[15:0];
				RegClipBottom: clip_bottom_q <= cfg_data[15:0];
				RegFillColor:  fill_color_q  <= cfg_data[15:0];
				RegRowStride:  row_stride_q  <= cfg_data[15:0];
				RegFrameBase:  frame_base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			left_edge_q <= '0; right_edge_q <= '0; left_slope_q <= '0; right_slope_q <= '0;
			current_row_q <= '0; rows_left_q <= '0; row_address_q <= '0;
			emit_q <= '0; trunc_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (trap.valid) begin
					item_q  <= trap.data;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (nrows_in <= 18'sd0) begin
						state_q <= S_IDLE;
					end else if (nrows_in == 18'sd1) begin
						// floor of the average
						left_edge_q   <= s1[32:1];
						right_edge_q  <= s2[32:1];
						left_slope_q  <= '0;
						right_slope_q <= '0;
						state_q <= S_CLIPM;
					end else begin
						left_edge_q  <= item_q.top_left_x;
						right_edge_q <= item_q.top_right_x;
						state_q <= S_DIVL;
					end
				end
				S_DIVL:  state_q <= S_WAITL;
				S_WAITL: if (drsp.done) begin
					left_slope_q <= drsp.quotient[31:0];
					state_q <= S_DIVR;
				end
				S_DIVR:  state_q <= S_WAITR;
				S_WAITR: if (drsp.done) begin
					right_slope_q <= drsp.quotient[31:0];
					state_q <= S_CLIPM;
				end
				S_CLIPM: begin
					if ((item_q.top_row < clip_top_q && item_q.bottom_row < clip_top_q)
						|| (y1c > 18'(clip_bottom_q)) || nrows_c <= 18'sd0) begin
						state_q <= S_IDLE;
					end else begin
						prod_l_q <= (item_q.top_row < clip_top_q)
							? 32'(32'(dy) * left_slope_q) : '0;
						prod_r_q <= (item_q.top_row < clip_top_q)
							? 32'(32'(dy) * right_slope_q) : '0;
						state_q <= S_CLIPA;
					end
				end
				S_CLIPA: begin
					left_edge_q   <= left_edge_q + prod_l_q;
					right_edge_q  <= right_edge_q + prod_r_q;
					current_row_q <= y1c[15:0];
					rows_left_q   <= 17'(nrows_c);
					trunc_q       <= nrows_c > 18'(MaxRows);
					emit_q        <= (nrows_c > 18'(MaxRows)) ? RowCntW'(MaxRows)
						: RowCntW'(nrows_c);
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					row_address_q <= frame_base_q + 32'(32'(current_row_q) * 32'(row_stride_q));
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					out_q.span_row      <= current_row_q;
					out_q.span_start    <= drw ? st : '0;
					out_q.span_end      <= drw ? en : '0;
					out_q.span_length   <= drw ? 17'(17'(en) - 17'(st) + 17'sd1) : '0;
					out_q.start_address <= drw ? row_address_q
						+ 32'(32'(st) * BytesPerPixel) : '0;
					out_q.span_color    <= fill_color_q;
					out_q.drawn         <= drw;
					out_q.last_span     <= emit_q == RowCntW'(1);
					out_q.truncated     <= trunc_q;
					out_valid_q         <= 1'b1;
					left_edge_q   <= le + ls;
					right_edge_q  <= re + rs;
					left_slope_q  <= ls;
					right_slope_q <= rs;
					current_row_q <= current_row_q + 16'sd1;
					rows_left_q   <= rows_left_q - 17'd1;
					row_address_q <= row_address_q + 32'(row_stride_q);
					emit_q        <= emit_q - RowCntW'(1);
					state_q <= S_OUT;
				end
				S_OUT: if (span.ready) begin
					out_valid_q <= 1'b0;
					state_q <= (emit_q == '0) ? S_IDLE : S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign trap.ready = (state_q == S_IDLE);
	assign span.valid = out_valid_q;
	assign span.data  = out_q;

	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == S_OUT) else $error("span valid outside output");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(span.valid && span.ready && out_q.last_span) |=> state_q == S_IDLE)
		else $error("last span did not end item");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> emit_q != '0) else $error("emit past count");
	a_drawn_len: assert property (@(posedge clk) disable iff (!arst_n)
		(span.valid && !out_q.drawn) |-> out_q.span_length == '0)
		else $error("undrawn span has length");
endmodule

@@ test/tsr_span_checker.sv @@
// Span checker: predicts span records from accepted trapezoids and compares them.
`timescale 1ns / 1ps
module tsr_span_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           trap_valid,
	input  logic           trap_ready,
	input  tsr_pkg::trap_t trap_data,
	input  logic           span_valid,
	input  logic           span_ready,
	input  tsr_pkg::span_t span_data,
	output int             fail_count,
	output int             outstanding,
	output int             spans_checked
);
	import tsr_pkg::*;

	logic signed [15:0] clip_left, clip_top, clip_right, clip_bottom;
	logic        [15:0] fill_color, row_stride;
	logic        [31:0] frame_base;

	span_t span_expect_q[$];

	function automatic void predict_spans(trap_t t);
		longint y1, y2, n, emit, ix1, ix2, st, en, s1, s2;
		logic signed [31:0] le, re, ls, rs, tmp;
		logic        [31:0] raddr;
		logic signed [15:0] crow;
		logic               trunc;
		span_t              s;
		y1 = t.top_row;
		y2 = t.bottom_row;
		n = y2 - y1 + 1;
		if (n <= 0) return;
		if (n > 1) begin
			ls = 32'((longint'(t.bottom_left_x) - longint'(t.top_left_x)) / (n - 1));
			rs = 32'((longint'(t.bottom_right_x) - longint'(t.top_right_x)) / (n - 1));
			le = t.top_left_x;
			re = t.top_right_x;
		end else begin
			// floor of the average of top and bottom x
			s1 = longint'(t.top_left_x) + longint'(t.bottom_left_x);
			s2 = longint'(t.top_right_x) + longint'(t.bottom_right_x);
			le = 32'(s1 >>> 1);
			re = 32'(s2 >>> 1);
			ls = '0;
			rs = '0;
		end
		if (y1 < clip_top) begin
			if (y2 < clip_top) return;
			le = le + 32'(longint'(clip_top) - y1) * ls;
			re = re + 32'(longint'(clip_top) - y1) * rs;
			y1 = clip_top;
		end
		if (y2 > clip_bottom) begin
			if (y1 > clip_bottom) return;
			y2 = clip_bottom;
		end
		n = y2 - y1 + 1;
		if (n <= 0) return;
		crow = 16'(y1);
		raddr = frame_base + 32'(y1) * {16'b0, row_stride};
		trunc = (n > MaxRows);
		emit = trunc ? MaxRows : n;
		for (int k = 0; k < emit; k++) begin
			// swap crossed edges together with their slopes
			if (le > re) begin
				tmp = le; le = re; re = tmp;
				tmp = ls; ls = rs; rs = tmp;
			end
			ix1 = longint'(signed'(le[31:16]));
			ix2 = longint'(signed'(re[31:16]));
			s = '0;
			if (ix2 >= clip_left && ix1 <= clip_right) begin
				st = (ix1 < clip_left) ? longint'(clip_left) : ix1;
				en = (ix2 > clip_right) ? longint'(clip_right) : ix2;
				if (st <= en) begin
					s.drawn = 1'b1;
					s.span_start = 16'(st);
					s.span_end = 16'(en);
					s.span_length = 17'(en - st + 1);
					s.start_address = raddr + 32'(st) * BytesPerPixel;
				end
			end
			s.span_row = crow;
			s.span_color = fill_color;
			s.last_span = (k == emit - 1);
			s.truncated = trunc;
			span_expect_q.push_back(s);
			crow = crow + 16'sd1;
			raddr = raddr + {16'b0, row_stride};
			le = le + ls;
			re = re + rs;
		end
	endfunction

	function automatic int compare_span(span_t e, span_t a);
		int bad;
		bad = 0;
		if (e.span_row !== a.span_row) begin
			$error("span_row expected %0d actual %0d", e.span_row, a.span_row); bad++;
		end
		if (e.span_start !== a.span_start) begin
			$error("span_start expected %0d actual %0d", e.span_start, a.span_start); bad++;
		end
		if (e.span_end !== a.span_end) begin
			$error("span_end expected %0d actual %0d", e.span_end, a.span_end); bad++;
		end
		if (e.span_length !== a.span_length) begin
			$error("span_length expected %0d actual %0d", e.span_length, a.span_length); bad++;
		end
		if (e.start_address !== a.start_address) begin
			$error("start_address expected %h actual %h", e.start_address, a.start_address);
			bad++;
		end
		if (e.span_color !== a.span_color) begin
			$error("span_color expected %h actual %h", e.span_color, a.span_color); bad++;
		end
		if (e.drawn !== a.drawn) begin
			$error("drawn expected %0d actual %0d", e.drawn, a.drawn); bad++;
		end
		if (e.last_span !== a.last_span) begin
			$error("last_span expected %0d actual %0d", e.last_span, a.last_span); bad++;
		end
		if (e.truncated !== a.truncated) begin
			$error("truncated expected %0d actual %0d", e.truncated, a.truncated); bad++;
		end
		return bad;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left <= '0; clip_top <= '0; clip_right <= '0; clip_bottom <= '0;
			fill_color <= '0; row_stride <= '0; frame_base <= '0;
			fail_count <= 0;
			outstanding <= 0;
			spans_checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegClipLeft:   clip_left   <= cfg_data[15:0];
					RegClipTop:    clip_top    <= cfg_data[15:0];
					RegClipRight:  clip_right  <= cfg_data[15:0];
					RegClipBottom: clip_bottom <= cfg_data[15:0];
					RegFillColor:  fill_color  <= cfg_data[15:0];
					RegRowStride:  row_stride  <= cfg_data[15:0];
					RegFrameBase:  frame_base  <= cfg_data;
					default: ;
				endcase
			end
			if (trap_valid && trap_ready) predict_spans(trap_data);
			if (span_valid && span_ready) begin
				spans_checked <= spans_checked + 1;
				if (span_expect_q.size() == 0) begin
					$error("span item with no expected span, row %0d", span_data.span_row);
					fail_count <= fail_count + 1;
				end else begin
					fail_count <= fail_count + compare_span(span_expect_q.pop_front(), span_data);
				end
			end
			outstanding <= span_expect_q.size();
		end
	end

endmodule

@@ test/tb_trapezoid_span_rasterizer.sv @@
// Testbench top: clock, reset, register settings, trapezoid stimulus and verdict.
`timescale 1ns / 1ps
module tb_trapezoid_span_rasterizer;
	import tsr_pkg::*;

	localparam int IdleLimit  = 6000;
	localparam int DrainWait  = 200;
	localparam int LongHold   = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	tsr_if #(.T(trap_t)) trap_ch ();
	tsr_if #(.T(span_t)) span_ch ();

	int fail_count, outstanding, spans_checked;
	int idle_cycles = 0;
	int traps_sent = 0;
	int settings_used = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	trapezoid_span_rasterizer dut (
		.clk(clk), .arst_n(arst_n), .trap(trap_ch), .span(span_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tsr_span_checker span_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.trap_valid(trap_ch.valid), .trap_ready(trap_ch.ready), .trap_data(trap_ch.data),
		.span_valid(span_ch.valid), .span_ready(span_ch.ready), .span_data(span_ch.data),
		.fail_count(fail_count), .outstanding(outstanding), .spans_checked(spans_checked)
	);

	initial begin
		trap_ch.valid = 1'b0;
		trap_ch.data = '0;
		span_ch.ready = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((trap_ch.valid && trap_ch.ready) || (span_ch.valid && span_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IdleLimit) begin
			$display("watchdog: no item moved for %0d cycles", IdleLimit);
			$display("FAIL trapezoid_span_rasterizer");
			$finish;
		end
	end

	// Span receiver: random stalls, one long hold-off on request.
	initial begin
		int r;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				span_ch.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				hold_done = 1'b1;
			end else if (calm) begin
				span_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					span_ch.ready <= 1'b1;
					repeat ($urandom_range(0, 15)) @(posedge clk);
				end else begin
					span_ch.ready <= 1'b0;
					repeat (r < 95 ? $urandom_range(0, 2) : $urandom_range(15, 60)) @(posedge clk);
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_clip(int cl, int ct, int cr, int cb, logic [15:0] color,
			logic [15:0] stride, logic [31:0] base);
		write_reg(RegClipLeft, 32'(cl));
		write_reg(RegClipTop, 32'(ct));
		write_reg(RegClipRight, 32'(cr));
		write_reg(RegClipBottom, 32'(cb));
		write_reg(RegFillColor, {16'b0, color});
		write_reg(RegRowStride, {16'b0, stride});
		write_reg(RegFrameBase, base);
		settings_used++;
	endtask

	// Lower valid and let all pending spans (and any silent item) drain.
	task automatic drain;
		@(posedge clk);
		trap_ch.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic send_trap(trap_t t, bit no_gap);
		int gap;
		gap = 0;
		if (!no_gap && !calm) begin
			gap = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(20, 50);
		end
		if (gap > 0) begin
			trap_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		trap_ch.valid <= 1'b1;
		trap_ch.data <= t;
		do @(negedge clk); while (!trap_ch.ready);
		@(posedge clk);
		traps_sent++;
	endtask

	function automatic logic [31:0] fx(int px, logic [15:0] frac);
		return {px[15:0], frac};
	endfunction

	function automatic trap_t make_trap(int y1, int y2, logic [31:0] tl, logic [31:0] tr,
			logic [31:0] bl, logic [31:0] br);
		trap_t t;
		t.top_row = 16'(y1);
		t.bottom_row = 16'(y2);
		t.top_left_x = tl;
		t.top_right_x = tr;
		t.bottom_left_x = bl;
		t.bottom_right_x = br;
		return t;
	endfunction

	function automatic logic [31:0] rand_x(bit wild);
		if (wild) return $urandom;
		return fx(int'($urandom_range(0, 160)) - 40, 16'($urandom));
	endfunction

	function automatic trap_t rand_trap();
		int mode, y1, y2, r;
		bit wild;
		mode = $urandom_range(0, 9);
		wild = (mode == 1);
		y1 = (mode == 0) ? int'(signed'(16'($urandom))) : int'($urandom_range(0, 120)) - 30;
		r = $urandom_range(0, 99);
		if (mode == 0 && r < 30) y2 = int'(signed'(16'($urandom)));
		else if (r < 5) y2 = y1 - int'($urandom_range(1, 5));
		else if (r < 15) y2 = y1;
		else if (r < 25) y2 = y1 + int'($urandom_range(64, 90));
		else y2 = y1 + int'($urandom_range(1, 40));
		return make_trap(y1, y2, rand_x(wild), rand_x(wild), rand_x(wild), rand_x(wild));
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) send_trap(rand_trap(), 1'b0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Widest clip box: directed extremes.
		set_clip(-32768, -32768, 32767, 32767, 16'hffff, 16'd640, 32'h8000_0000);
		calm = 1'b1;
		send_trap(make_trap(10, 10, fx(5, 16'h8000), fx(20, 0), fx(-6, 16'h0001),
			fx(21, 16'hffff)), 1'b1);                                 // single row, odd sum
		send_trap(make_trap(20, 19, fx(1, 0), fx(9, 0), fx(1, 0), fx(9, 0)), 1'b1);
		send_trap(make_trap(-32768, 32767, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000), 1'b1);                   // extremes, crossing
		send_trap(make_trap(32767, 32767, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff), 1'b1);
		send_trap(make_trap(-32768, -32768, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000), 1'b1);
		calm = 1'b0;
		send_trap(make_trap(0, 9, fx(30, 0), fx(0, 0), fx(0, 0), fx(30, 0)), 1'b0);
		send_trap(make_trap(0, 99, fx(0, 0), fx(50, 0), fx(10, 0), fx(60, 0)), 1'b0);
		drain();

		// Small box: vertical and horizontal clipping.
		set_clip(0, 0, 63, 47, 16'h1234, 16'd128, 32'h0001_0000);
		send_trap(make_trap(-20, 10, fx(-10, 0), fx(70, 0), fx(5, 16'h4000), fx(40, 0)), 1'b0);
		send_trap(make_trap(-30, -1, fx(0, 0), fx(10, 0), fx(0, 0), fx(10, 0)), 1'b0);
		send_trap(make_trap(48, 60, fx(0, 0), fx(10, 0), fx(0, 0), fx(10, 0)), 1'b0);
		send_trap(make_trap(30, 90, fx(-50, 0), fx(-40, 0), fx(100, 0), fx(120, 0)), 1'b0);
		send_trap(make_trap(5, 8, fx(64, 0), fx(90, 0), fx(64, 0), fx(90, 0)), 1'b0);
		send_trap(make_trap(5, 8, fx(-9, 0), fx(-1, 16'hffff), fx(-9, 0), fx(-1, 0)), 1'b0);
		send_trap(make_trap(-100, 100, fx(0, 0), fx(63, 0), fx(63, 0), fx(0, 0)), 1'b0);
		// Hold the span side off while trapezoids keep coming.
		hold_req = 1'b1;
		run_random(8);
		trap_ch.valid <= 1'b0;
		while (!hold_done) @(posedge clk);
		run_random(50);
		drain();

		// Inverted box: nothing is drawn; empty vertical range too.
		set_clip(40, 10, 20, 30, 16'h00ff, 16'd0, 32'hffff_fff0);
		send_trap(make_trap(0, 50, fx(0, 0), fx(63, 0), fx(10, 0), fx(50, 0)), 1'b0);
		run_random(10);
		drain();
		set_clip(0, 30, 63, 10, 16'h0f0f, 16'd8, 32'h0);
		send_trap(make_trap(0, 50, fx(0, 0), fx(63, 0), fx(10, 0), fx(50, 0)), 1'b0);
		run_random(5);
		drain();

		// Random settings.
		for (int p = 0; p < 3; p++) begin
			set_clip(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20,
				int'($urandom_range(20, 140)), int'($urandom_range(20, 100)),
				16'($urandom), 16'($urandom), $urandom);
			run_random(30);
			drain();
		end

		// Extreme stride and base with the widest box.
		set_clip(-32768, -32768, 32767, 32767, 16'h0000, 16'hffff, 32'hffff_ffff);
		calm = (1'b1);
		run_random(10);
		calm = 1'b0;
		run_random(25);
		drain();

		while (outstanding != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
		if (outstanding != 0) $error("%0d expected spans never arrived", outstanding);
		$display("ran %0d trapezoids through %0d register settings, %0d spans checked",
			traps_sent, settings_used, spans_checked);
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASS trapezoid_span_rasterizer");
		end else begin
			$display("FAIL trapezoid_span_rasterizer");
		end
		$finish;
	end

endmodule

@@ trapezoid_span_rasterizer.f @@
src/tsr_pkg.sv
src/tsr_if.sv
src/tsr_div.sv
src/trapezoid_span_rasterizer.sv
test/tsr_span_checker.sv
test/tb_trapezoid_span_rasterizer.sv
